[rtl/bmprle_pkg.sv]
// Shared types, codes and constants for the bitmap run-length run decoder.
`timescale 1ns / 1ps

package bmprle_pkg;

	// Field widths of the word and result interfaces.
	localparam int CMD_W   = 2;
	localparam int KIND_W  = 2;
	localparam int COORD_W = 13;
	localparam int COLOR_W = 32;
	localparam int RGB_W   = 24;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// Largest side that the raster cursor honours; width and height saturate here.
	localparam int unsigned MAX_SIDE = 4096;

	// Default number of palette slots.
	localparam int PALETTE_DEPTH_DEF = 256;

	// Depth of the result queue in front of the output.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
	localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
	localparam logic [3:0]         NIBBLE_MASK  = 4'hF;

	// Input commands.
	localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_FILL     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRUNC    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BADDELTA = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd3;

	// Escape codes that follow a zero count byte.
	localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
	localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
	localparam logic [BYTE_W-1:0] ESC_ABS_MIN = 8'd3;

	// One result record.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COLOR_W-1:0] even;
		logic [COLOR_W-1:0] odd;
		logic               last;
	} run_rec_t;

endpackage

[rtl/bmprle_ram.sv]
// Generic single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps

module bmprle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/bmp_rle_run_decoder_top.sv]
// Top level of the bitmap run-length decoder: parser, palette and result queue.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid / in_ready) carries one word per handshake: a palette
// load, a compressed data byte or a restart. The output channel (out_valid /
// out_ready) carries one run record per word handshake. Configuration registers
// are written through cfg_we / cfg_index / cfg_data while the block is idle.
// A word accepted at one edge has its palette colours read at that edge, is parsed
// in the following cycle if the result queue has room, else held until it has,
// and its results are written into the result queue in front of the output.
// The single parse stage takes one input word per cycle while the result queue has
// room; a data byte that yields two results takes two output handshakes, and the
// output port passes at most one result per cycle.
// The parse stage advances only while the four-entry result queue has room for
// two records; when the receiver stalls the queue fills and in_ready falls.
// Reset: the cursor and parse state clear, the configuration returns to its
// defaults and every palette slot reads as opaque black at once, through one valid
// bit per slot; there is no clearing pass. A restart word clears the cursor and
// parse state but keeps the palette.
module bmp_rle_run_decoder_top #(
	parameter int PALETTE_DEPTH = bmprle_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port
	input  logic                              cfg_we,
	input  logic [bmprle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmprle_pkg::CFG_W-1:0]      cfg_data,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bmprle_pkg::CMD_W-1:0]      command,
	input  logic [bmprle_pkg::BYTE_W-1:0]     palette_index,
	input  logic [bmprle_pkg::RGB_W-1:0]      palette_color,
	input  logic [bmprle_pkg::BYTE_W-1:0]     data_byte,
	input  logic                              final_byte,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bmprle_pkg::KIND_W-1:0]     run_kind,
	output logic [bmprle_pkg::COORD_W-1:0]    start_x,
	output logic [bmprle_pkg::COORD_W-1:0]    start_y,
	output logic [bmprle_pkg::COORD_W-1:0]    end_x,
	output logic [bmprle_pkg::COORD_W-1:0]    end_y,
	output logic [bmprle_pkg::COLOR_W-1:0]    even_color,
	output logic [bmprle_pkg::COLOR_W-1:0]    odd_color,
	output logic                              run_last
);

	import bmprle_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int EXT_W  = COORD_W + 1;
	localparam int SIDE_W = 17;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_SECOND,
		PH_LITERAL,
		PH_PAD,
		PH_DX,
		PH_DY
	} phase_t;

	// Configuration registers
	logic                 four_bit_q;
	logic [COORD_W-1:0]   width_q;
	logic [COORD_W-1:0]   height_q;
	logic [COLOR_W-1:0]   bg_color_q;

	// Palette valid bits and read addresses
	logic [PALETTE_DEPTH-1:0] pal_valid_q;
	logic [BYTE_W-1:0]        rd_addr_even;
	logic [BYTE_W-1:0]        rd_addr_odd;
	logic                     even_in_range;
	logic                     odd_in_range;
	logic                     pal_we;
	logic [COLOR_W-1:0]       pal_wdata;
	logic [COLOR_W-1:0]       ram_even;
	logic [COLOR_W-1:0]       ram_odd;

	// Parse stage register
	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 final_s1;
	logic                 even_vld_s1;
	logic                 odd_vld_s1;
	logic [COLOR_W-1:0]   even_s1;
	logic [COLOR_W-1:0]   odd_s1;

	// Parse state
	phase_t               phase_q, nxt_phase;
	logic [COORD_W-1:0]   cx_q, nxt_cx;
	logic [COORD_W-1:0]   cy_q, nxt_cy;
	logic [BYTE_W-1:0]    held_q, nxt_held;
	logic [BYTE_W-1:0]    lit_q, nxt_lit;
	logic                 pad_q, nxt_pad;
	logic                 fin_q, nxt_fin;

	// Parse datapath
	logic                 in_accept;
	logic                 proc_go;
	logic [COORD_W-1:0]   eff_w;
	logic [COORD_W-1:0]   eff_h;
	logic [COORD_W-1:0]   row_left;
	logic [EXT_W-1:0]     w_ext, h_ext, cx_ext, cy_ext;
	logic [EXT_W-1:0]     delta_tx, delta_ty;
	logic [BYTE_W:0]      byte_plus_one;
	logic                 fill_en;
	logic [COORD_W-1:0]   fill_n;
	logic                 skip_en;
	logic                 skip_nz;
	logic [EXT_W-1:0]     skip_tx, skip_ty;
	logic                 status_en;
	logic [KIND_W-1:0]    status_kind;
	logic                 run_any;
	run_rec_t             run_rec, status_rec, rec0, rec1;
	logic [1:0]           n_res;

	// Result queue
	run_rec_t             fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign in_accept = in_valid && in_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q <= 1'b0;
			width_q    <= COORD_W'(1);
			height_q   <= COORD_W'(1);
			bg_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FOUR_BIT: four_bit_q <= cfg_data[0];
				CFG_WIDTH:    width_q    <= cfg_data[COORD_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[COORD_W-1:0];
				CFG_BG_COLOR: bg_color_q <= cfg_data[COLOR_W-1:0];
				default:      ;
			endcase
		end
	end

	// Palette addressing: high and low nibble in four-bit mode, the whole byte otherwise.
	assign rd_addr_even  = four_bit_q ? {4'b0, data_byte[7:4]} : data_byte;
	assign rd_addr_odd   = four_bit_q ? {4'b0, data_byte[3:0] & NIBBLE_MASK} : data_byte;
	assign even_in_range = ({1'b0, rd_addr_even} < (BYTE_W + 1)'(PALETTE_DEPTH));
	assign odd_in_range  = ({1'b0, rd_addr_odd} < (BYTE_W + 1)'(PALETTE_DEPTH));
	assign pal_we        = in_accept && (command == CMD_PALETTE) &&
	                       ({1'b0, palette_index} < (BYTE_W + 1)'(PALETTE_DEPTH));
	assign pal_wdata     = {ALPHA_OPAQUE, palette_color};

	// Two copies of the palette so both colours of a byte are read together.
	bmprle_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_even (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[PAL_AW-1:0]),
		.wdata (pal_wdata),
		.re    (in_accept),
		.raddr (rd_addr_even[PAL_AW-1:0]),
		.rdata (ram_even)
	);

	bmprle_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_odd (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[PAL_AW-1:0]),
		.wdata (pal_wdata),
		.re    (in_accept),
		.raddr (rd_addr_odd[PAL_AW-1:0]),
		.rdata (ram_odd)
	);

	// Slot valid bits: a slot never loaded reads as opaque black.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_we) begin
			pal_valid_q[palette_index[PAL_AW-1:0]] <= 1'b1;
		end
	end

	// Parse stage register.
	assign in_ready = !valid_s1 || proc_go;
	assign proc_go  = valid_s1 && (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= command;
			byte_s1     <= data_byte;
			final_s1    <= final_byte;
			even_vld_s1 <= even_in_range && pal_valid_q[rd_addr_even[PAL_AW-1:0]];
			odd_vld_s1  <= odd_in_range && pal_valid_q[rd_addr_odd[PAL_AW-1:0]];
		end
	end

	assign even_s1 = even_vld_s1 ? ram_even : OPAQUE_BLACK;
	assign odd_s1  = odd_vld_s1 ? ram_odd : OPAQUE_BLACK;

	// Image size saturated to the largest side, and the pixels left in the row.
	assign eff_w = ({4'b0, width_q} < SIDE_W'(MAX_SIDE)) ? width_q : COORD_W'(MAX_SIDE);
	assign eff_h = ({4'b0, height_q} < SIDE_W'(MAX_SIDE)) ? height_q : COORD_W'(MAX_SIDE);
	assign row_left = (cx_q < eff_w) ? (eff_w - cx_q) : '0;

	assign w_ext    = {1'b0, eff_w};
	assign h_ext    = {1'b0, eff_h};
	assign cx_ext   = {1'b0, cx_q};
	assign cy_ext   = {1'b0, cy_q};
	assign delta_tx = cx_ext + {{(EXT_W - BYTE_W){1'b0}}, held_q};
	assign delta_ty = cy_ext + {{(EXT_W - BYTE_W){1'b0}}, byte_s1};
	assign byte_plus_one = {1'b0, byte_s1} + (BYTE_W + 1)'(1);

	// Parser: next state and the results of the word in the parse stage.
	always_comb begin
		logic [BYTE_W-1:0] px;
		px          = '0;
		nxt_phase   = phase_q;
		nxt_cx      = cx_q;
		nxt_cy      = cy_q;
		nxt_held    = held_q;
		nxt_lit     = lit_q;
		nxt_pad     = pad_q;
		nxt_fin     = fin_q;
		fill_en     = 1'b0;
		fill_n      = '0;
		skip_en     = 1'b0;
		skip_tx     = '0;
		skip_ty     = '0;
		status_en   = 1'b0;
		status_kind = KIND_COMPLETE;
		skip_nz     = 1'b0;

		if (proc_go && (cmd_s1 == CMD_RESTART)) begin
			nxt_phase = PH_COUNT;
			nxt_cx    = '0;
			nxt_cy    = '0;
			nxt_held  = '0;
			nxt_lit   = '0;
			nxt_pad   = 1'b0;
			nxt_fin   = 1'b0;
		end else if (proc_go && (cmd_s1 == CMD_DATA) && !fin_q) begin
			case (phase_q)
				PH_SECOND: begin
					nxt_phase = PH_COUNT;
					if (held_q != '0) begin
						// Encoded run clipped at the row end.
						fill_n  = ({5'b0, held_q} < row_left) ? {5'b0, held_q} : row_left;
						fill_en = (fill_n != '0);
					end else if (byte_s1 >= ESC_ABS_MIN) begin
						// Absolute run: count pixels, then padding to a 16-bit word.
						nxt_lit   = byte_s1;
						nxt_pad   = four_bit_q ? byte_plus_one[1] : byte_s1[0];
						nxt_phase = PH_LITERAL;
					end else if (byte_s1 == ESC_EOL) begin
						skip_en   = 1'b1;
						skip_ty   = cy_ext + EXT_W'(1);
						status_en = (cy_ext + EXT_W'(1)) == h_ext;
					end else if (byte_s1 == ESC_EOB) begin
						skip_en   = 1'b1;
						skip_ty   = h_ext;
						status_en = 1'b1;
					end else begin
						nxt_phase = PH_DX;
					end
				end
				PH_LITERAL: begin
					if (four_bit_q) begin
						px = (lit_q >= 8'd2) ? 8'd2 : lit_q;
					end else begin
						px = {7'b0, (lit_q != '0)};
					end
					fill_n  = ({5'b0, px} < row_left) ? {5'b0, px} : row_left;
					fill_en = (fill_n != '0);
					nxt_lit = lit_q - px;
					if (nxt_lit == '0) begin
						nxt_phase = pad_q ? PH_PAD : PH_COUNT;
					end
				end
				PH_PAD: begin
					nxt_pad   = 1'b0;
					nxt_phase = PH_COUNT;
				end
				PH_DX: begin
					nxt_held  = byte_s1;
					nxt_phase = PH_DY;
				end
				PH_DY: begin
					nxt_phase = PH_COUNT;
					if ((delta_tx > w_ext) || (delta_ty > h_ext)) begin
						status_en   = 1'b1;
						status_kind = KIND_BADDELTA;
					end else if (delta_ty == h_ext) begin
						// A delta onto the row just past the bottom row completes the image.
						skip_en   = 1'b1;
						skip_ty   = h_ext;
						status_en = 1'b1;
					end else begin
						skip_en = 1'b1;
						skip_tx = delta_tx;
						skip_ty = delta_ty;
					end
				end
				default: begin
					nxt_held  = byte_s1;
					nxt_phase = PH_SECOND;
				end
			endcase

			// Background fill from the cursor to the skip target, if it covers any pixel.
			if (skip_ty > cy_ext) begin
				skip_nz = !((skip_tx == '0) && (cx_q >= eff_w) &&
				            ((eff_w == '0) || (skip_ty == cy_ext + EXT_W'(1))));
			end else begin
				skip_nz = (skip_ty == cy_ext) && (skip_tx > cx_ext);
			end

			if (fill_en) begin
				nxt_cx = cx_q + fill_n;
			end
			if (skip_en) begin
				nxt_cx = skip_tx[COORD_W-1:0];
				nxt_cy = skip_ty[COORD_W-1:0];
			end
			if (status_en) begin
				nxt_fin = 1'b1;
			end
			// Last byte with the image unfinished: report truncation.
			if (final_s1 && !nxt_fin) begin
				status_en   = 1'b1;
				status_kind = KIND_TRUNC;
				nxt_fin     = 1'b1;
			end
		end
	end

	// Result records: a fill run first, then a status record at the new cursor.
	assign run_any = fill_en || (skip_en && skip_nz);

	always_comb begin
		run_rec.kind = KIND_FILL;
		run_rec.sx   = cx_q;
		run_rec.sy   = cy_q;
		run_rec.ex   = skip_en ? skip_tx[COORD_W-1:0] : (cx_q + fill_n);
		run_rec.ey   = skip_en ? skip_ty[COORD_W-1:0] : cy_q;
		run_rec.even = skip_en ? bg_color_q : even_s1;
		run_rec.odd  = skip_en ? bg_color_q : (four_bit_q ? odd_s1 : even_s1);
		run_rec.last = !status_en;

		status_rec.kind = status_kind;
		status_rec.sx   = nxt_cx;
		status_rec.sy   = nxt_cy;
		status_rec.ex   = nxt_cx;
		status_rec.ey   = nxt_cy;
		status_rec.even = '0;
		status_rec.odd  = '0;
		status_rec.last = 1'b1;

		rec0  = run_any ? run_rec : status_rec;
		rec1  = status_rec;
		n_res = {1'b0, run_any} + {1'b0, status_en};
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			cx_q    <= '0;
			cy_q    <= '0;
			held_q  <= '0;
			lit_q   <= '0;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= nxt_phase;
			cx_q    <= nxt_cx;
			cy_q    <= nxt_cy;
			held_q  <= nxt_held;
			lit_q   <= nxt_lit;
			pad_q   <= nxt_pad;
			fin_q   <= nxt_fin;
		end
	end

	// Result queue: up to two pushes and one pop per cycle.
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= rec0;
		end
		if (n_res == 2'd2) begin
			fifo_q[wr_ptr_q + OUT_PTR_W'(1)] <= rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_res);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			cnt_q <= cnt_q + OUT_CNT_W'(n_res) - OUT_CNT_W'(pop);
		end
	end

	assign run_kind   = fifo_q[rd_ptr_q].kind;
	assign start_x    = fifo_q[rd_ptr_q].sx;
	assign start_y    = fifo_q[rd_ptr_q].sy;
	assign end_x      = fifo_q[rd_ptr_q].ex;
	assign end_y      = fifo_q[rd_ptr_q].ey;
	assign even_color = fifo_q[rd_ptr_q].even;
	assign odd_color  = fifo_q[rd_ptr_q].odd;
	assign run_last   = fifo_q[rd_ptr_q].last;

	// The queue never holds more records than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue overflow");

	// Results are only produced by a word that the parse stage actually advances.
	a_push_needs_go: assert property (@(posedge clk) disable iff (!arst_n)
		(n_res != 2'd0) |-> proc_go)
		else $error("results pushed without an advancing word");

	// A finished image gives no results for further data bytes.
	a_quiet_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_go && fin_q && (cmd_s1 == CMD_DATA)) |-> (n_res == 2'd0))
		else $error("results after image finished");

	// With two results the first is always a fill run and the second a status.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(n_res == 2'd2) |-> ((rec0.kind == KIND_FILL) && (rec1.kind != KIND_FILL)))
		else $error("bad ordering of a result pair");

	// A status word marks the image finished at the next edge.
	a_status_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		status_en |=> fin_q)
		else $error("status emitted without finishing the image");

endmodule
